### rtl/mvu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvu_pkg: shared types and constants of the meter bank
// Widths, MIDI codes, register indexes, the velocity scale table and the
// records passed between the scaler, the cells and the top level.
// ----------------------------------------------------------------------------
package mvu_pkg;

    // bank geometry
    localparam int NUM_BARS  = 32;
    localparam int MAX_LEVEL = 39;
    localparam int CH_BARS   = 16;
    localparam int LVL_W     = 6;
    localparam int BAR_W     = 5;
    localparam int CNT_W     = $clog2(NUM_BARS);
    localparam int GAIN_W    = 8;
    localparam int VEL_W     = 7;
    localparam int NOTE_W    = 7;

    // MIDI decoding
    localparam logic [3:0]        NOTE_ON_NIB = 4'h9;
    localparam logic [NOTE_W-1:0] NOTE_MIN    = NOTE_W'(35);
    localparam logic [NOTE_W-1:0] NOTE_BASE   = NOTE_W'(36);
    localparam logic [5:0]        BAR_MOD     = 6'd31;

    // request kinds carried in tuser
    localparam logic REQ_MIDI = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // configuration register indexes
    localparam logic CFG_BY_CHANNEL = 1'b0;
    localparam logic CFG_GAIN       = 1'b1;
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(150);

    // floor(x / 100) as (x * DIV100_MUL) >> DIV100_SH, exact for x below 43690
    localparam int PROD_W     = LVL_W + GAIN_W;
    localparam int DIV100_W   = 14;
    localparam int DIV100_SH  = 20;
    localparam logic [DIV100_W-1:0] DIV100_MUL = DIV100_W'(10486);

    // velocity to level table: floor(v * MAX_LEVEL / 127)
    typedef logic [LVL_W-1:0] t_scale_tbl [128];

    function automatic t_scale_tbl build_scale_tbl();
        t_scale_tbl tbl;
        for (int i = 0; i < 128; i++) begin
            tbl[i] = LVL_W'((i * MAX_LEVEL) / 127);
        end
        return tbl;
    endfunction

    localparam t_scale_tbl SCALE_TBL = build_scale_tbl();

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_TICK
    } t_state;

    // level pair held by one cell
    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [LVL_W-1:0] shown;
    } t_bar;

    // note-on entering the scaler
    typedef struct packed {
        logic             vld;
        logic [BAR_W-1:0] bar;
        logic [VEL_W-1:0] vel;
    } t_note;

    // scaled note-on broadcast to the cells
    typedef struct packed {
        logic             vld;
        logic [BAR_W-1:0] bar;
        logic [LVL_W-1:0] lvl;
    } t_upd;

endpackage
`default_nettype wire

### rtl/mvu_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvu_scale: velocity scaling pipeline
// Three stages: table lookup, gain multiply, divide by 100 and clamp.
// ----------------------------------------------------------------------------
module mvu_scale (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire mvu_pkg::t_note           i_note,
    input  wire [mvu_pkg::GAIN_W-1:0]     i_gain,
    output mvu_pkg::t_upd                 o_upd,
    output logic                          o_busy
);

    logic                              r_s1_vld;
    logic [mvu_pkg::BAR_W-1:0]         r_s1_bar;
    logic [mvu_pkg::LVL_W-1:0]         r_s1_lvl;
    logic                              r_s2_vld;
    logic [mvu_pkg::BAR_W-1:0]         r_s2_bar;
    logic [mvu_pkg::PROD_W-1:0]        r_s2_prod;
    mvu_pkg::t_upd                     r_upd;
    mvu_pkg::t_upd                     n_upd;

    logic [mvu_pkg::PROD_W+mvu_pkg::DIV100_W-1:0] quot_full;
    logic [mvu_pkg::PROD_W+mvu_pkg::DIV100_W-mvu_pkg::DIV100_SH-1:0] quot;

    // divide by 100 and clamp to the top level
    always_comb begin
        quot_full = (mvu_pkg::PROD_W + mvu_pkg::DIV100_W)'(r_s2_prod)
                  * (mvu_pkg::PROD_W + mvu_pkg::DIV100_W)'(mvu_pkg::DIV100_MUL);
        quot      = quot_full[mvu_pkg::PROD_W+mvu_pkg::DIV100_W-1:mvu_pkg::DIV100_SH];
        n_upd.vld = r_s2_vld;
        n_upd.bar = r_s2_bar;
        if (quot > $bits(quot)'(mvu_pkg::MAX_LEVEL)) begin
            n_upd.lvl = mvu_pkg::LVL_W'(mvu_pkg::MAX_LEVEL);
        end else begin
            n_upd.lvl = mvu_pkg::LVL_W'(quot);
        end
    end

    // valid bits of the stages and the output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_upd.vld <= 1'b0;
        end else begin
            r_s1_vld  <= i_note.vld;
            r_s2_vld  <= r_s1_vld;
            r_upd     <= n_upd;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        r_s1_bar  <= i_note.bar;
        r_s1_lvl  <= mvu_pkg::SCALE_TBL[i_note.vel];
        r_s2_bar  <= r_s1_bar;
        r_s2_prod <= mvu_pkg::PROD_W'(r_s1_lvl) * mvu_pkg::PROD_W'(i_gain);
    end

    assign o_upd  = r_upd;
    assign o_busy = r_s1_vld | r_s2_vld | r_upd.vld;

endmodule
`default_nettype wire

### rtl/mvu_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvu_cell: one meter cell of the ring
// Holds a level and its shown level; raises the level on a matching
// note-on and takes its neighbor's pair when the ring rotates.
// ----------------------------------------------------------------------------
module mvu_cell (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire [mvu_pkg::BAR_W-1:0]      i_idx,
    input  wire                           i_shift,
    input  wire mvu_pkg::t_bar            i_next,
    input  wire mvu_pkg::t_upd            i_upd,
    output mvu_pkg::t_bar                 o_bar
);

    mvu_pkg::t_bar r_bar;

    // rotate, or peak-hold on a note-on for this bar
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar <= '0;
        end else if (i_shift) begin
            r_bar <= i_next;
        end else if (i_upd.vld && (i_upd.bar == i_idx) && (i_upd.lvl > r_bar.level)) begin
            r_bar.level <= i_upd.lvl;
        end
    end

    assign o_bar = r_bar;

endmodule
`default_nettype wire

### rtl/midi_vu_meter_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// midi_vu_meter_bank: peak-hold level meters driven by MIDI note-ons
// Input stream requests are MIDI messages or decay ticks (tuser). A note-on
// raises one bar; a tick decays and reports every active bar.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis takes one request per cycle while idle. A MIDI request passes
//   through the lookup / gain multiply / divide-by-100 pipeline into its
//   bar; it gives no result.
//   A tick waits for that pipeline to drain, then rotates the ring of
//   NUM_BARS cells once, one cell per cycle while the receiver does not
//   stall, decaying each active bar at the head cell and emitting a
//   result on m_axis for it (32 bars in note mode, 16 in channel mode),
//   tlast on the final one. s_axis is not ready until the rotation ends.
//   In channel mode the inactive half still rotates, silently.
//   m_axis is fed from an output register: when the receiver stalls the
//   ring holds its position until the result is taken.
//   Reset clears all levels and shown levels, sets note mode and gain 150.
//   The config channel is always ready: index 0 by_channel, 1 gain_percent,
//   to be written only while the block is idle.
// ----------------------------------------------------------------------------
module midi_vu_meter_bank (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire [23:0]  i_s_axis_tdata,   // status_byte[7:0], note_number[14:8], velocity_in[21:15]
    input  wire [0:0]   i_s_axis_tuser,   // req_type[0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // bar_index[4:0], level_now[10:5], level_shown[16:11], grew[17]
    output logic        o_m_axis_tlast,
    // configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [0:0]   i_cfg_index,
    input  wire [7:0]   i_cfg_data
);

    localparam int N = mvu_pkg::NUM_BARS;

    // config registers
    logic                          r_by_ch;
    logic [mvu_pkg::GAIN_W-1:0]    r_gain;

    // controller
    mvu_pkg::t_state               r_state;
    mvu_pkg::t_state               n_state;
    logic [mvu_pkg::CNT_W-1:0]     r_cnt;
    logic [mvu_pkg::CNT_W-1:0]     n_cnt;
    logic                          adv;
    logic [mvu_pkg::CNT_W:0]       active;
    logic                          in_act;
    logic                          s_acc;

    // input decode
    logic [7:0]                    st_byte;
    logic [mvu_pkg::NOTE_W-1:0]    note;
    logic [mvu_pkg::VEL_W-1:0]     vel;
    logic [mvu_pkg::NOTE_W-1:0]    note_off;
    logic [5:0]                    half;
    logic [5:0]                    bar6;
    logic [mvu_pkg::BAR_W-1:0]     bar_sel;
    logic                          note_ok;
    mvu_pkg::t_note                note_req;

    // scaler and ring
    mvu_pkg::t_upd                 upd;
    logic                          pipe_busy;
    mvu_pkg::t_bar                 bars [N];
    mvu_pkg::t_bar                 head_next;
    logic [mvu_pkg::LVL_W-1:0]     now_lvl;

    // output register
    logic                          r_out_vld;
    logic [mvu_pkg::BAR_W-1:0]     r_out_bar;
    logic [mvu_pkg::LVL_W-1:0]     r_out_now;
    logic [mvu_pkg::LVL_W-1:0]     r_out_shown;
    logic                          r_out_grew;
    logic                          r_out_last;

    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_by_ch <= 1'b0;
            r_gain  <= mvu_pkg::GAIN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index[0])
                mvu_pkg::CFG_BY_CHANNEL: r_by_ch <= i_cfg_data[0];
                mvu_pkg::CFG_GAIN:       r_gain  <= i_cfg_data;
                default:                 r_gain  <= r_gain;
            endcase
        end
    end

    // note-on decode and bar selection
    always_comb begin
        st_byte  = i_s_axis_tdata[7:0];
        note     = i_s_axis_tdata[14:8];
        vel      = i_s_axis_tdata[21:15];
        note_off = note - mvu_pkg::NOTE_BASE;
        half     = note_off[6:1];
        if (note <= mvu_pkg::NOTE_BASE) begin
            bar6 = 6'd0;
        end else if (half >= mvu_pkg::BAR_MOD) begin
            bar6 = half - mvu_pkg::BAR_MOD;
        end else begin
            bar6 = half;
        end
        bar_sel = r_by_ch ? mvu_pkg::BAR_W'(st_byte[3:0]) : bar6[mvu_pkg::BAR_W-1:0];
        note_ok = (i_s_axis_tuser[0] == mvu_pkg::REQ_MIDI)
               && (st_byte[7:4] == mvu_pkg::NOTE_ON_NIB)
               && (vel != '0)
               && (r_by_ch || (note >= mvu_pkg::NOTE_MIN))
               && ({1'b0, bar_sel} < (mvu_pkg::BAR_W + 1)'(active));
        note_req.vld = s_acc && note_ok;
        note_req.bar = bar_sel;
        note_req.vel = vel;
    end

    mvu_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_note  (note_req),
        .i_gain  (r_gain),
        .o_upd   (upd),
        .o_busy  (pipe_busy)
    );

    // head cell leaves the ring decayed when its bar is active
    always_comb begin
        now_lvl = (bars[0].level != '0) ? bars[0].level - 1'b1 : bars[0].level;
        if (in_act) begin
            head_next.level = now_lvl;
            head_next.shown = now_lvl;
        end else begin
            head_next = bars[0];
        end
    end

    // ring of cells, rotating toward cell 0
    for (genvar g = 0; g < N; g++) begin : g_cell
        mvu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (mvu_pkg::BAR_W'(g)),
            .i_shift (adv),
            .i_next  ((g == N - 1) ? head_next : bars[(g + 1) % N]),
            .i_upd   (upd),
            .o_bar   (bars[g])
        );
    end

    // controller next state
    always_comb begin
        active  = r_by_ch ? (mvu_pkg::CNT_W + 1)'(mvu_pkg::CH_BARS)
                          : (mvu_pkg::CNT_W + 1)'(N);
        in_act  = {1'b0, r_cnt} < active;
        o_s_axis_tready = (r_state == mvu_pkg::ST_IDLE);
        s_acc   = i_s_axis_tvalid && o_s_axis_tready;
        adv     = (r_state == mvu_pkg::ST_TICK) && !pipe_busy
               && (!r_out_vld || i_m_axis_tready);
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            mvu_pkg::ST_IDLE: begin
                if (s_acc && (i_s_axis_tuser[0] == mvu_pkg::REQ_TICK)) begin
                    n_state = mvu_pkg::ST_TICK;
                    n_cnt   = '0;
                end
            end
            mvu_pkg::ST_TICK: begin
                if (adv) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt == mvu_pkg::CNT_W'(N - 1)) begin
                        n_state = mvu_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = mvu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mvu_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && in_act) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (adv && in_act) begin
            r_out_bar   <= mvu_pkg::BAR_W'(r_cnt);
            r_out_now   <= now_lvl;
            r_out_shown <= bars[0].shown;
            r_out_grew  <= now_lvl > bars[0].shown;
            r_out_last  <= ({1'b0, r_cnt} + 1'b1) == active;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'd0, r_out_grew, r_out_shown, r_out_now, r_out_bar};
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTH
    // a tick ends after one full rotation
    a_tick_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_cnt == mvu_pkg::CNT_W'(N - 1)) |=> (r_state == mvu_pkg::ST_IDLE))
        else $error("tick did not end after full rotation");

    // an accepted tick starts a rotation
    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_axis_tuser[0] == mvu_pkg::REQ_TICK) |=> (r_state == mvu_pkg::ST_TICK))
        else $error("tick not started");

    // the ring never rotates under a pending note-on
    a_no_race: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd.vld && r_state == mvu_pkg::ST_TICK) |-> !adv)
        else $error("ring rotated while a note-on was landing");

    // the last result carries the last active bar
    a_last_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_last) |-> ((mvu_pkg::CNT_W + 1)'(r_out_bar) + 1'b1 == active))
        else $error("tlast on the wrong bar");

    // the head cell's level stays within range
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bars[0].level <= mvu_pkg::LVL_W'(mvu_pkg::MAX_LEVEL))
        else $error("level above maximum");
`endif

endmodule
`default_nettype wire

### sim/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for the MIDI level meter bank
// Drives MIDI messages, decay ticks and register writes with random gaps
// and receiver stalls. A local meter model predicts every bar report, and
// the reports are checked in order against that prediction.
// ----------------------------------------------------------------------------
module tb;
    import mvu_pkg::*;

    // long enough for the silent half of a channel-mode rotation to finish
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_SHOWN_ERR = 10;

    // what one queued stimulus step does
    typedef enum logic [1:0] {
        ACT_REQ,
        ACT_CFG,
        ACT_HOLD
    } t_action;

    typedef struct {
        t_action          act;
        logic             req_type;
        logic [7:0]       status;
        logic [6:0]       note;
        logic [6:0]       vel;
        logic             cfg_idx;
        logic [7:0]       cfg_val;
        logic             calm;
    } t_step;

    // one bar report as the block should emit it
    typedef struct packed {
        logic [BAR_W-1:0] bar;
        logic [LVL_W-1:0] now;
        logic [LVL_W-1:0] shown;
        logic             grew;
        logic             last;
    } t_report;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid    = 1'b0;
    logic [23:0] s_tdata    = '0;
    logic [0:0]  s_tuser    = '0;
    logic        m_ready    = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [0:0]  cfg_index  = '0;
    logic [7:0]  cfg_data   = '0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [23:0] o_m_axis_tdata;
    wire         o_m_axis_tlast;
    wire         o_cfg_ready;

    midi_vu_meter_bank dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // meter model state and bookkeeping
    logic [LVL_W-1:0]  meter_level [NUM_BARS];
    logic [LVL_W-1:0]  meter_shown [NUM_BARS];
    logic              mtr_by_channel;
    logic [GAIN_W-1:0] mtr_gain;
    t_step             midi_traffic [$];
    t_report           reports_due [$];
    t_step             inflight;
    logic              quiet_phase = 1'b0;
    logic              calm_now    = 1'b0;
    int                gap_left    = 0;
    int                hold_left   = 0;
    int                stall_left  = 0;
    int                mismatch_count = 0;
    int                items_sent  = 0;
    int                ticks_sent  = 0;
    int                cfg_writes  = 0;
    int                reports_seen = 0;

    // clock and reset
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // apply one accepted request to the meter model, queue the bar reports
    task automatic meter_step(input t_step s);
        int bar;
        int lvl;
        int note_val;
        int count;
        t_report r;
        count    = mtr_by_channel ? CH_BARS : NUM_BARS;
        note_val = int'(s.note);
        if (s.req_type == REQ_MIDI) begin
            if (s.status[7:4] != NOTE_ON_NIB || s.vel == 0)
                return;
            if (mtr_by_channel) begin
                bar = int'(s.status[3:0]);
            end else begin
                if (note_val < int'(NOTE_MIN))
                    return;
                if (note_val <= int'(NOTE_BASE))
                    bar = 0;
                else
                    bar = ((note_val - int'(NOTE_BASE)) / 2) % int'(BAR_MOD);
            end
            if (bar >= count)
                return;
            lvl = (int'(s.vel) * MAX_LEVEL) / 127;
            lvl = (lvl * int'(mtr_gain)) / 100;
            if (lvl > MAX_LEVEL)
                lvl = MAX_LEVEL;
            if (int'(meter_level[bar]) < lvl)
                meter_level[bar] = LVL_W'(lvl);
            return;
        end
        // decay tick: drop every active bar, then report and latch shown levels
        for (int i = 0; i < count; i++) begin
            if (meter_level[i] != 0)
                meter_level[i] = meter_level[i] - 1'b1;
        end
        for (int i = 0; i < count; i++) begin
            r.bar   = BAR_W'(i);
            r.now   = meter_level[i];
            r.shown = meter_shown[i];
            r.grew  = meter_level[i] > meter_shown[i];
            r.last  = (i == count - 1);
            reports_due.push_back(r);
            meter_shown[i] = meter_level[i];
        end
    endtask

    // request and register write driver
    always @(posedge i_clk) begin : req_driver
        t_step cur;
        logic  busy;
        logic  took;
        logic  nxt_valid;
        logic  nxt_cfg;
        if (!i_rst_n) begin
            s_valid   <= 1'b0;
            cfg_valid <= 1'b0;
            mtr_by_channel = 1'b0;
            mtr_gain       = GAIN_RESET;
            for (int i = 0; i < NUM_BARS; i++) begin
                meter_level[i] = '0;
                meter_shown[i] = '0;
            end
        end else begin
            busy      = s_valid | cfg_valid;
            took      = 1'b0;
            nxt_valid = s_valid;
            nxt_cfg   = cfg_valid;
            if (s_valid && o_s_axis_tready) begin
                meter_step(inflight);
                items_sent++;
                if (inflight.req_type == REQ_TICK)
                    ticks_sent++;
                nxt_valid = 1'b0;
                took      = 1'b1;
            end
            if (cfg_valid && o_cfg_ready) begin
                if (inflight.cfg_idx == CFG_BY_CHANNEL)
                    mtr_by_channel = inflight.cfg_val[0];
                else
                    mtr_gain = inflight.cfg_val;
                cfg_writes++;
                nxt_cfg = 1'b0;
                took    = 1'b1;
            end
            if (took) begin
                busy = 1'b0;
                if (!quiet_phase && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 3);
            end
            // next step from the queue once the previous one is done
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (hold_left > 0) begin
                    if (reports_due.size() == 0)
                        hold_left--;
                end else if (midi_traffic.size() != 0) begin
                    cur = midi_traffic.pop_front();
                    inflight = cur;
                    quiet_phase <= cur.calm;
                    case (cur.act)
                        ACT_REQ: begin
                            nxt_valid = 1'b1;
                            s_tdata <= {2'b00, cur.vel, cur.note, cur.status};
                            s_tuser <= cur.req_type;
                        end
                        ACT_CFG: begin
                            nxt_cfg = 1'b1;
                            cfg_index <= cur.cfg_idx;
                            cfg_data  <= cur.cfg_val;
                        end
                        default: begin
                            hold_left = SETTLE_CYCLES;
                        end
                    endcase
                end
            end
            s_valid   <= nxt_valid;
            cfg_valid <= nxt_cfg;
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin : report_checker
        t_report want;
        t_report got;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                reports_seen++;
                got.bar   = o_m_axis_tdata[4:0];
                got.now   = o_m_axis_tdata[10:5];
                got.shown = o_m_axis_tdata[16:11];
                got.grew  = o_m_axis_tdata[17];
                got.last  = o_m_axis_tlast;
                if (reports_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN_ERR)
                        $display("unexpected report: bar %0d now %0d shown %0d grew %0d last %0d",
                                 got.bar, got.now, got.shown, got.grew, got.last);
                end else begin
                    want = reports_due.pop_front();
                    if (want.bar !== got.bar || want.now !== got.now ||
                        want.shown !== got.shown || want.grew !== got.grew ||
                        want.last !== got.last) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_SHOWN_ERR)
                            $display({"report mismatch: expected bar %0d now %0d shown %0d ",
                                      "grew %0d last %0d, got bar %0d now %0d shown %0d ",
                                      "grew %0d last %0d"},
                                     want.bar, want.now, want.shown, want.grew, want.last,
                                     got.bar, got.now, got.shown, got.grew, got.last);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // stimulus builders
    task automatic add_req(input logic rt, input logic [7:0] st,
                           input logic [6:0] nt, input logic [6:0] vl);
        t_step s;
        s = '{act: ACT_REQ, req_type: rt, status: st, note: nt, vel: vl,
              cfg_idx: CFG_BY_CHANNEL, cfg_val: 8'h00, calm: calm_now};
        midi_traffic.push_back(s);
    endtask

    task automatic add_hold();
        t_step s;
        s = '{act: ACT_HOLD, req_type: REQ_MIDI, status: 8'h00, note: 7'h00, vel: 7'h00,
              cfg_idx: CFG_BY_CHANNEL, cfg_val: 8'h00, calm: calm_now};
        midi_traffic.push_back(s);
    endtask

    // register writes only after the bank has gone quiet
    task automatic add_cfg(input logic idx, input logic [7:0] val);
        t_step s;
        add_hold();
        s = '{act: ACT_CFG, req_type: REQ_MIDI, status: 8'h00, note: 7'h00, vel: 7'h00,
              cfg_idx: idx, cfg_val: val, calm: calm_now};
        midi_traffic.push_back(s);
    endtask

    task automatic add_random_req();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            add_req(REQ_TICK, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                    7'($urandom_range(0, 127)));
        end else if (pick < 40) begin
            // noise: any status, any velocity including zero
            add_req(REQ_MIDI, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                    7'($urandom_range(0, 127)));
        end else begin
            add_req(REQ_MIDI, {NOTE_ON_NIB, 4'($urandom_range(0, 15))},
                    ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(35, 127)),
                    7'($urandom_range(1, 127)));
        end
    endtask

    // stimulus plan and end of run
    initial begin : run_ctrl
        logic [1:0]  mode_sel [5];
        logic [7:0]  gain_sel [5];
        // directed: empty bank, extremes, ignored messages, wrap of the note map
        add_req(REQ_TICK, 8'h00, 7'd0, 7'd0);
        add_req(REQ_MIDI, 8'h90, 7'd35, 7'd127);
        add_req(REQ_MIDI, 8'h90, 7'd34, 7'd127);
        add_req(REQ_MIDI, 8'h9F, 7'd127, 7'd64);
        add_req(REQ_MIDI, 8'h93, 7'd98, 7'd100);
        add_req(REQ_MIDI, 8'h90, 7'd36, 7'd1);
        add_req(REQ_MIDI, 8'h95, 7'd60, 7'd0);
        add_req(REQ_MIDI, 8'h80, 7'd60, 7'd127);
        add_req(REQ_MIDI, 8'hFF, 7'd127, 7'd127);
        add_req(REQ_MIDI, 8'h90, 7'd97, 7'd127);
        add_req(REQ_TICK, 8'hFF, 7'd127, 7'd127);
        add_req(REQ_TICK, 8'h90, 7'd60, 7'd100);
        // zero and full gain
        add_cfg(CFG_GAIN, 8'd0);
        add_req(REQ_MIDI, 8'h91, 7'd50, 7'd127);
        add_cfg(CFG_GAIN, 8'd255);
        add_req(REQ_MIDI, 8'h92, 7'd52, 7'd127);
        add_req(REQ_MIDI, 8'h92, 7'd54, 7'd10);
        add_req(REQ_TICK, 8'h00, 7'd0, 7'd0);
        // channel mode: upper half must keep its levels
        add_cfg(CFG_BY_CHANNEL, 8'd1);
        add_req(REQ_MIDI, 8'h9F, 7'd0, 7'd127);
        add_req(REQ_MIDI, 8'h90, 7'd10, 7'd50);
        add_req(REQ_MIDI, 8'h8F, 7'd10, 7'd50);
        add_req(REQ_TICK, 8'h00, 7'd0, 7'd0);
        add_cfg(CFG_BY_CHANNEL, 8'd0);
        add_cfg(CFG_GAIN, GAIN_RESET);
        add_req(REQ_TICK, 8'h00, 7'd0, 7'd0);
        add_req(REQ_MIDI, 8'h9A, 7'd126, 7'd127);
        add_req(REQ_TICK, 8'h00, 7'd0, 7'd0);
        // random phases over several register settings, last one without idling
        mode_sel = '{2'd0, 2'd1, 2'd1, 2'd0, 2'd0};
        gain_sel = '{8'd255, 8'd0, 8'($urandom_range(100, 255)),
                     8'($urandom_range(0, 255)), 8'd150};
        for (int p = 0; p < 5; p++) begin
            calm_now = (p == 4);
            add_cfg(CFG_BY_CHANNEL, {7'd0, mode_sel[p][0]});
            add_cfg(CFG_GAIN, gain_sel[p]);
            for (int k = 0; k < 15; k++) begin
                if (p == 2 && k == 11)
                    add_hold();
                add_random_req();
            end
        end

        wait (i_rst_n === 1'b1);
        while (midi_traffic.size() != 0 || s_valid || cfg_valid || hold_left != 0)
            @(posedge i_clk);
        while (reports_due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("covered %0d requests (%0d ticks) and %0d register writes",
                 items_sent, ticks_sent, cfg_writes);
        $display("checked %0d bar reports, %0d mismatches", reports_seen, mismatch_count);
        if (mismatch_count == 0 && reports_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
